@@ rtl/rpai_pkg.sv @@
// Shared types, constants and the arctangent table for the annulus intersector.
package rpai_pkg;

   localparam int CW       = 21;
   localparam int TW       = 20;
   localparam int PW       = 32;
   localparam int AW       = 35;
   localparam int ACC_W    = 32;
   localparam int DW       = 64;
   localparam int DIV_BITS = 20;
   localparam int CORDIC_N = 30;

   localparam logic [2:0] CSR_CENTER = 3'd0;
   localparam logic [2:0] CSR_NORMAL = 3'd1;
   localparam logic [2:0] CSR_INNER  = 3'd2;
   localparam logic [2:0] CSR_OUTER  = 3'd3;
   localparam logic [2:0] CSR_MIN    = 3'd4;
   localparam logic [2:0] CSR_MAX    = 3'd5;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [PW-1:0] point_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] i);
      logic [ACC_W-1:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/rpai_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module rpai_div #(
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [rpai_pkg::DW-1:0]       in_dividend,
   input  logic [rpai_pkg::DW-1:0]       in_divisor,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [rpai_pkg::DIV_BITS-1:0] out_quotient,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int N = rpai_pkg::DIV_BITS;

   logic                  valid_ff [0:N];
   logic [rpai_pkg::DW-1:0] rem_ff [0:N];
   logic [rpai_pkg::DW-1:0] dvs_ff [0:N];
   logic [N-1:0]          quo_ff   [0:N];
   logic [SIDE_W-1:0]     side_ff  [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         rem_ff[0]  <= in_dividend;
         dvs_ff[0]  <= in_divisor;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int B = N - 1 - k;
      logic [rpai_pkg::DW-1:0] sub;
      logic                    ge;
      logic [rpai_pkg::DW-1:0] rem_in;
      logic [N-1:0]            quo_in;

      always_comb begin
         sub    = dvs_ff[k] << B;
         ge     = rem_ff[k] >= sub;
         rem_in = ge ? rem_ff[k] - sub : rem_ff[k];
         quo_in = quo_ff[k];
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (advance) begin
            rem_ff[k+1]  <= rem_in;
            dvs_ff[k+1]  <= dvs_ff[k];
            quo_ff[k+1]  <= quo_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid    = valid_ff[N];
   assign out_quotient = quo_ff[N];
   assign out_side     = side_ff[N];

endmodule

@@ rtl/rpai_cordic.sv @@
// Pipelined vectoring CORDIC giving the azimuth in 2^-32 turn.
module rpai_cordic #(
   parameter int SIDE_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [rpai_pkg::AW-1:0]    in_x,
   input  logic signed [rpai_pkg::AW-1:0]    in_y,
   input  logic [rpai_pkg::ACC_W-1:0]        in_acc,
   input  logic                              in_skip,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic [rpai_pkg::ACC_W-1:0]        out_acc,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int N = rpai_pkg::CORDIC_N;

   logic                              valid_ff [0:N];
   logic signed [rpai_pkg::AW-1:0]    x_ff     [0:N];
   logic signed [rpai_pkg::AW-1:0]    y_ff     [0:N];
   logic [rpai_pkg::ACC_W-1:0]        acc_ff   [0:N];
   logic                              skip_ff  [0:N];
   logic [SIDE_W-1:0]                 side_ff  [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         x_ff[0]    <= in_x;
         y_ff[0]    <= in_y;
         acc_ff[0]  <= in_acc;
         skip_ff[0] <= in_skip;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic signed [rpai_pkg::AW-1:0] x_in;
      logic signed [rpai_pkg::AW-1:0] y_in;
      logic [rpai_pkg::ACC_W-1:0]     acc_in;

      always_comb begin
         x_in   = x_ff[k];
         y_in   = y_ff[k];
         acc_in = acc_ff[k];
         if (!skip_ff[k]) begin
            if (y_ff[k] > 0) begin
               x_in   = x_ff[k] + (y_ff[k] >>> k);
               y_in   = y_ff[k] - (x_ff[k] >>> k);
               acc_in = acc_ff[k] + rpai_pkg::atan_turn(5'(k));
            end else begin
               x_in   = x_ff[k] - (y_ff[k] >>> k);
               y_in   = y_ff[k] + (x_ff[k] >>> k);
               acc_in = acc_ff[k] - rpai_pkg::atan_turn(5'(k));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (advance) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            acc_ff[k+1]  <= acc_in;
            skip_ff[k+1] <= skip_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_acc   = acc_ff[N];
   assign out_side  = side_ff[N];

endmodule

@@ rtl/ray_part_annulus_intersect_top.sv @@
// Top level: ray against flat annulus sector intersection pipeline.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   origin and direction of one ray
//  rsp      out        rsp_valid/rsp_stall   hit flag, distance, hit point
//  csr      in         csr_write_enable      csr_index, csr_data
//
// One transaction per cycle unless rsp_stall holds a waiting response; the path from request
// to response register runs through the 20-stage divider and the 30-stage CORDIC.
// Synchronous reset clears valid bits and loads register defaults.
// rsp_stall holds the whole pipeline while a response waits; req_stall follows it then.
module ray_part_annulus_intersect_top #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [20:0]      req_origin_x,
   input  logic signed [20:0]      req_origin_y,
   input  logic signed [20:0]      req_origin_z,
   input  logic signed [20:0]      req_dir_x,
   input  logic signed [20:0]      req_dir_y,
   input  logic signed [20:0]      req_dir_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_hit,
   output logic [19:0]             rsp_hit_distance,
   output logic signed [20:0]      rsp_point_x,
   output logic signed [20:0]      rsp_point_y,
   output logic signed [20:0]      rsp_point_z,
   input  logic                    csr_write_enable,
   input  logic [2:0]              csr_index,
   input  logic [62:0]             csr_data
);

   localparam int CW = rpai_pkg::CW;
   localparam int PW = rpai_pkg::PW;
   localparam int TW = rpai_pkg::TW;
   localparam int DSIDE_W = 2 + 9 * CW;
   localparam int CSIDE_W = 1 + TW + 3 * PW;

   // configuration
   logic [62:0] center_ff, normal_ff;
   logic [43:0] inner_ff, outer_ff;
   logic [15:0] min_ff, max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         normal_ff <= 63'(64'd4294967296);
         inner_ff  <= '0;
         outer_ff  <= 44'd16777216;
         min_ff    <= '0;
         max_ff    <= 16'hFFFF;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rpai_pkg::CSR_CENTER: center_ff <= csr_data;
            rpai_pkg::CSR_NORMAL: normal_ff <= csr_data;
            rpai_pkg::CSR_INNER:  inner_ff  <= csr_data[43:0];
            rpai_pkg::CSR_OUTER:  outer_ff  <= csr_data[43:0];
            rpai_pkg::CSR_MIN:    min_ff    <= csr_data[15:0];
            rpai_pkg::CSR_MAX:    max_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   rpai_pkg::coord_type cen [3];
   rpai_pkg::coord_type nrm [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cen[k] = center_ff[CW*(2-k) +: CW];
         nrm[k] = normal_ff[CW*(2-k) +: CW];
      end
   end

   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: products
   rpai_pkg::coord_type req_o [3];
   rpai_pkg::coord_type req_d [3];
   assign req_o[0] = req_origin_x;
   assign req_o[1] = req_origin_y;
   assign req_o[2] = req_origin_z;
   assign req_d[0] = req_dir_x;
   assign req_d[1] = req_dir_y;
   assign req_d[2] = req_dir_z;

   logic                s1_valid_ff;
   logic signed [42:0]  s1_pn_ff [3];
   logic signed [41:0]  s1_pd_ff [3];
   rpai_pkg::coord_type s1_o_ff [3];
   rpai_pkg::coord_type s1_d_ff [3];
   rpai_pkg::coord_type s1_c_ff [3];
   logic signed [42:0]  s1_pn_in [3];
   logic signed [41:0]  s1_pd_in [3];
   logic signed [CW:0]  diff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]     = (CW+1)'(cen[k]) - (CW+1)'(req_o[k]);
         s1_pn_in[k] = 43'(diff[k]) * 43'(nrm[k]);
         s1_pd_in[k] = 42'(req_d[k]) * 42'(nrm[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            s1_pn_ff[k] <= s1_pn_in[k];
            s1_pd_ff[k] <= s1_pd_in[k];
            s1_o_ff[k]  <= req_o[k];
            s1_d_ff[k]  <= req_d[k];
            s1_c_ff[k]  <= cen[k];
         end
      end
   end

   // stage 2: dot products
   logic                s2_valid_ff;
   logic signed [44:0]  s2_num_ff;
   logic signed [43:0]  s2_den_ff;
   rpai_pkg::coord_type s2_o_ff [3];
   rpai_pkg::coord_type s2_d_ff [3];
   rpai_pkg::coord_type s2_c_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_num_ff <= 45'(s1_pn_ff[0]) + 45'(s1_pn_ff[1]) + 45'(s1_pn_ff[2]);
         s2_den_ff <= 44'(s1_pd_ff[0]) + 44'(s1_pd_ff[1]) + 44'(s1_pd_ff[2]);
         s2_o_ff   <= s1_o_ff;
         s2_d_ff   <= s1_d_ff;
         s2_c_ff   <= s1_c_ff;
      end
   end

   // stage 3: magnitudes, early miss, saturation, into divider
   logic                    s2_miss, s2_sat;
   logic [44:0]             s2_an;
   logic [43:0]             s2_ad;
   logic [rpai_pkg::DW-1:0] s2_an_w, s2_ad_w;
   logic [DSIDE_W-1:0]      div_side_in, div_side_out;
   logic                    div_valid;
   logic [TW-1:0]           div_q;

   always_comb begin
      s2_miss = (s2_den_ff == '0) || (s2_num_ff == '0) || (s2_num_ff[44] != s2_den_ff[43]);
      s2_an   = s2_num_ff[44] ? 45'(-s2_num_ff) : 45'(s2_num_ff);
      s2_ad   = s2_den_ff[43] ? 44'(-s2_den_ff) : 44'(s2_den_ff);
      s2_an_w = rpai_pkg::DW'(s2_an);
      s2_ad_w = rpai_pkg::DW'(s2_ad);
      s2_sat  = s2_an_w >= (s2_ad_w << (TW - 11));
      div_side_in = {s2_miss, s2_sat,
                     s2_o_ff[0], s2_o_ff[1], s2_o_ff[2],
                     s2_d_ff[0], s2_d_ff[1], s2_d_ff[2],
                     s2_c_ff[0], s2_c_ff[1], s2_c_ff[2]};
   end

   rpai_div #(.SIDE_W(DSIDE_W)) u_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s2_valid_ff),
      .in_dividend (s2_sat ? '0 : (s2_an_w << 11)),
      .in_divisor  (s2_ad_w),
      .in_side     (div_side_in),
      .out_valid   (div_valid),
      .out_quotient(div_q),
      .out_side    (div_side_out)
   );

   // stage 4: t * d
   logic                dv_miss, dv_sat;
   rpai_pkg::coord_type dv_o [3];
   rpai_pkg::coord_type dv_d [3];
   rpai_pkg::coord_type dv_c [3];
   logic [TW-1:0]       dv_t;
   assign {dv_miss, dv_sat, dv_o[0], dv_o[1], dv_o[2],
           dv_d[0], dv_d[1], dv_d[2], dv_c[0], dv_c[1], dv_c[2]} = div_side_out;
   assign dv_t = dv_sat ? '1 : div_q;

   logic                s4_valid_ff, s4_miss_ff;
   logic [TW-1:0]       s4_t_ff;
   logic signed [41:0]  s4_prod_ff [3];
   rpai_pkg::coord_type s4_o_ff [3];
   rpai_pkg::coord_type s4_c_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= div_valid;
      end
      if (advance) begin
         s4_miss_ff <= dv_miss;
         s4_t_ff    <= dv_t;
         for (int k = 0; k < 3; k++) begin
            s4_prod_ff[k] <= $signed({22'd0, dv_t}) * 42'(dv_d[k]);
            s4_o_ff[k]    <= dv_o[k];
            s4_c_ff[k]    <= dv_c[k];
         end
      end
   end

   // stage 5: hit point
   logic [41:0]         s4_mag [3];
   logic [30:0]         s4_rnd [3];
   rpai_pkg::point_type s5_p_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s4_mag[k]  = s4_prod_ff[k][41] ? 42'(-s4_prod_ff[k]) : 42'(s4_prod_ff[k]);
         s4_rnd[k]  = 31'((s4_mag[k] + 42'd1024) >> 11);
         s5_p_in[k] = PW'(s4_o_ff[k]) +
                      (s4_prod_ff[k][41] ? -PW'(s4_rnd[k]) : PW'(s4_rnd[k]));
      end
   end

   logic                s5_valid_ff, s5_miss_ff;
   logic [TW-1:0]       s5_t_ff;
   rpai_pkg::point_type s5_p_ff [3];
   rpai_pkg::coord_type s5_c_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_miss_ff <= s4_miss_ff;
         s5_t_ff    <= s4_t_ff;
         s5_p_ff    <= s5_p_in;
         s5_c_ff    <= s4_c_ff;
      end
   end

   // stage 6: squared offsets
   logic signed [PW:0] s5_dx [3];
   logic [PW-1:0]      s5_dm [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s5_dx[k] = (PW+1)'(s5_p_ff[k]) - (PW+1)'(s5_c_ff[k]);
         s5_dm[k] = s5_dx[k][PW] ? PW'(-s5_dx[k]) : PW'(s5_dx[k]);
      end
   end

   logic                s6_valid_ff, s6_miss_ff;
   logic [TW-1:0]       s6_t_ff;
   rpai_pkg::point_type s6_p_ff [3];
   logic [63:0]         s6_sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         s6_miss_ff <= s5_miss_ff;
         s6_t_ff    <= s5_t_ff;
         s6_p_ff    <= s5_p_ff;
         for (int k = 0; k < 3; k++) begin
            s6_sq_ff[k] <= 64'(s5_dm[k]) * 64'(s5_dm[k]);
         end
      end
   end

   // stage 7: radius test
   logic [63:0]         s6_dsq;
   logic                s7_valid_ff, s7_fail_ff;
   logic [TW-1:0]       s7_t_ff;
   rpai_pkg::point_type s7_p_ff [3];

   assign s6_dsq = s6_sq_ff[0] + s6_sq_ff[1] + s6_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= s6_valid_ff;
      end
      if (advance) begin
         s7_fail_ff <= s6_miss_ff || !(s6_dsq > 64'(inner_ff) && s6_dsq < 64'(outer_ff));
         s7_t_ff    <= s6_t_ff;
         s7_p_ff    <= s6_p_ff;
      end
   end

   // azimuth setup
   logic signed [rpai_pkg::AW-1:0] cx, cy;
   logic [rpai_pkg::ACC_W-1:0]     cacc;
   logic                           cskip;
   logic [CSIDE_W-1:0]             cor_side_in, cor_side_out;
   logic                           cor_valid;
   logic [rpai_pkg::ACC_W-1:0]     cor_acc;

   always_comb begin
      cx    = rpai_pkg::AW'(s7_p_ff[2]);
      cy    = rpai_pkg::AW'(s7_p_ff[0]);
      cacc  = '0;
      cskip = 1'b0;
      priority if (cy == '0) begin
         cskip = 1'b1;
         cacc  = cx < 0 ? 32'h80000000 : 32'h00000000;
      end else if (cx == '0) begin
         cskip = 1'b1;
         cacc  = cy > 0 ? 32'h40000000 : 32'hC0000000;
      end else if (cx < 0) begin
         cx   = -cx;
         cy   = -cy;
         cacc = 32'h80000000;
      end else begin
         cacc = '0;
      end
      cor_side_in = {s7_fail_ff, s7_t_ff, s7_p_ff[0], s7_p_ff[1], s7_p_ff[2]};
   end

   rpai_cordic #(.SIDE_W(CSIDE_W)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (s7_valid_ff),
      .in_x     (cx),
      .in_y     (cy),
      .in_acc   (cacc),
      .in_skip  (cskip),
      .in_side  (cor_side_in),
      .out_valid(cor_valid),
      .out_acc  (cor_acc),
      .out_side (cor_side_out)
   );

   // window test and response register
   logic                       co_fail;
   logic [TW-1:0]              co_t;
   rpai_pkg::point_type        co_p [3];
   logic [rpai_pkg::ACC_W-1:0] ang_rnd, ang;
   logic                       hit;
   logic signed [CW-1:0]       co_sat [3];

   assign {co_fail, co_t, co_p[0], co_p[1], co_p[2]} = cor_side_out;

   always_comb begin
      ang_rnd = cor_acc + (32'd1 << (31 - ANGLE_BITS));
      ang     = ang_rnd >> (32 - ANGLE_BITS);
      hit     = !co_fail && ang >= 32'(min_ff) && ang <= 32'(max_ff);
      for (int k = 0; k < 3; k++) begin
         priority if (co_p[k] > PW'(1048575)) begin
            co_sat[k] = 21'sd1048575;
         end else if (co_p[k] < -PW'(1048576)) begin
            co_sat[k] = -21'sd1048576;
         end else begin
            co_sat[k] = co_p[k][CW-1:0];
         end
      end
   end

   logic                 rsp_hit_ff;
   logic [TW-1:0]        rsp_t_ff;
   logic signed [CW-1:0] rsp_p_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cor_valid;
      end
      if (advance) begin
         rsp_hit_ff <= hit;
         rsp_t_ff   <= hit ? co_t : '0;
         for (int k = 0; k < 3; k++) begin
            rsp_p_ff[k] <= hit ? co_sat[k] : '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_hit       = rsp_hit_ff;
   assign rsp_hit_distance = rsp_t_ff;
   assign rsp_point_x      = rsp_p_ff[0];
   assign rsp_point_y      = rsp_p_ff[1];
   assign rsp_point_z      = rsp_p_ff[2];

endmodule
